[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the merge core checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define KCM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define KCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  `KCM_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

// Next-cycle implication.
`define KCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  `KCM_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

[design/kcm_pkg.sv]
// ----------------------------------------------------------------------------
// kcm_pkg
// Types and constants shared by the clause merge core.
// ----------------------------------------------------------------------------
package kcm_pkg;

  localparam int MAX_SOURCES_DEF = 8;
  localparam int MAX_LITS_DEF    = 32;
  localparam logic [3:0]  CFG_RESET     = 4'd8;
  localparam logic [63:0] NO_CLAUSE_ID  = '1;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_APPEND = 2'd1,
    OP_END    = 2'd2,
    OP_NEXT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP_ADDR,
    S_CMP_CHK,
    S_OUT_ADDR,
    S_OUT_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic next_i;
    logic take_min;
    logic cmp_init;
    logic drop;
    logic flag_mism;
    logic k_inc;
    logic out_init;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic elig;
    logic less;
    logic eq;
    logic len_ne;
    logic lit_ne;
    logic k_last;
    logic win_empty;
  } sts_t;

endpackage

[design/kcm_ram.sv]
// ----------------------------------------------------------------------------
// kcm_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/kcm_ctrl.sv]
// ----------------------------------------------------------------------------
// kcm_ctrl
// Sequencer for scan, duplicate compare and result streaming.
// ----------------------------------------------------------------------------
module kcm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    op,
  input  kcm_pkg::sts_t sts,
  output kcm_pkg::cmd_t cmd,
  output logic          busy
);
  import kcm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_NEXT) begin
            cmd.scan_init = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          cmd.out_init = 1'b1;
          state_next = S_OUT_ADDR;
        end else if (!sts.elig) begin
          cmd.next_i = 1'b1;
        end else if (sts.less) begin
          cmd.take_min = 1'b1;
          cmd.next_i = 1'b1;
        end else if (sts.eq) begin
          if (!sts.len_ne && !sts.win_empty) begin
            cmd.cmp_init = 1'b1;
            state_next = S_CMP_ADDR;
          end else begin
            cmd.drop = 1'b1;
            cmd.flag_mism = sts.len_ne;
          end
        end else begin
          cmd.next_i = 1'b1;
        end
      end
      S_CMP_ADDR: state_next = S_CMP_CHK;
      S_CMP_CHK: begin
        if (sts.lit_ne || sts.k_last) begin
          cmd.drop = 1'b1;
          cmd.flag_mism = sts.lit_ne;
          state_next = S_SCAN;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = S_CMP_ADDR;
        end
      end
      S_OUT_ADDR: state_next = S_OUT_EMIT;
      S_OUT_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.win_empty || sts.k_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = S_OUT_ADDR;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[design/kcm_dp.sv]
// ----------------------------------------------------------------------------
// kcm_dp
// Head clause store, scan registers, literal RAM and result registers.
// ----------------------------------------------------------------------------
module kcm_dp #(
  parameter int MAX_SOURCES = 8,
  parameter int MAX_LITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  kcm_pkg::cmd_t       cmd,
  output kcm_pkg::sts_t       sts,
  input  logic [1:0]          op,
  input  logic [2:0]          source,
  input  logic [63:0]         clause_id,
  input  logic [5:0]          lit_count,
  input  logic signed [31:0]  literal,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  output logic [63:0]         merged_id,
  output logic [2:0]          winner_source,
  output logic signed [31:0]  out_literal,
  output logic                literal_valid,
  output logic                last,
  output logic                mismatch,
  output logic [7:0]          freed_sources,
  output logic                result_valid
);
  import kcm_pkg::*;

  localparam int SW    = $clog2(MAX_SOURCES);
  localparam int CW    = $clog2(MAX_SOURCES + 1);
  localparam int LW    = $clog2(MAX_LITS + 1);
  localparam int DEPTH = MAX_SOURCES * MAX_LITS;
  localparam int AW    = $clog2(DEPTH);

  logic [63:0]   head_id   [MAX_SOURCES];
  logic [LW-1:0] head_len  [MAX_SOURCES];
  logic [LW-1:0] head_fill [MAX_SOURCES];
  logic          source_done [MAX_SOURCES];

  logic [3:0]    cfg_count;
  logic [CW-1:0] i;
  logic [CW-1:0] cnt;
  logic [SW-1:0] win;
  logic [63:0]   cur;
  logic [LW-1:0] win_len;
  logic [LW-1:0] k;
  logic          have;
  logic          mism;
  logic [7:0]    freed;

  logic [SW-1:0] ii;
  logic [SW-1:0] sidx;
  logic          src_ok;
  logic [LW-1:0] lit_sat;
  logic          app_ok;
  logic [CW-1:0] eff_count;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]   rd_a, rd_b;

  assign ii      = i[SW-1:0];
  assign sidx    = SW'(source);
  assign src_ok  = (32'(source) < MAX_SOURCES);
  assign lit_sat = (32'(lit_count) > MAX_LITS) ? LW'(MAX_LITS) : LW'(lit_count);
  assign app_ok  = src_ok && !source_done[sidx] && (head_id[sidx] != NO_CLAUSE_ID) &&
                   (head_fill[sidx] < head_len[sidx]);
  assign eff_count = (32'(cfg_count) > MAX_SOURCES) ? CW'(MAX_SOURCES) : CW'(cfg_count);

  assign waddr   = AW'(sidx) * AW'(MAX_LITS) + AW'(head_fill[sidx]);
  assign raddr_a = AW'(win) * AW'(MAX_LITS) + AW'(k);
  assign raddr_b = AW'(ii) * AW'(MAX_LITS) + AW'(k);

  kcm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_lits (
    .clk     (clk),
    .we      (cmd.load && (op == OP_APPEND) && app_ok),
    .waddr   (waddr),
    .wdata   (literal),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    sts.scan_end  = (i >= cnt);
    sts.elig      = (head_id[ii] != NO_CLAUSE_ID) && (head_fill[ii] == head_len[ii]);
    sts.less      = (head_id[ii] < cur);
    sts.eq        = (head_id[ii] == cur);
    sts.len_ne    = (head_len[ii] != win_len);
    sts.lit_ne    = (rd_a != rd_b);
    sts.k_last    = (k == win_len - LW'(1));
    sts.win_empty = (win_len == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count    <= CFG_RESET;
      have         <= 1'b0;
      mism         <= 1'b0;
      freed        <= '0;
      result_valid <= 1'b0;
      i            <= '0;
      cnt          <= '0;
      k            <= '0;
      win          <= '0;
      win_len      <= '0;
      cur          <= NO_CLAUSE_ID;
      for (int s = 0; s < MAX_SOURCES; s++) begin
        head_id[s]     <= NO_CLAUSE_ID;
        head_len[s]    <= '0;
        head_fill[s]   <= '0;
        source_done[s] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        cfg_count <= cfg_wdata;
      end
      if (cmd.load && src_ok) begin
        case (op)
          OP_END: begin
            source_done[sidx] <= 1'b1;
            head_id[sidx]     <= NO_CLAUSE_ID;
            head_len[sidx]    <= '0;
            head_fill[sidx]   <= '0;
          end
          OP_BEGIN: begin
            if (!source_done[sidx]) begin
              if (clause_id == '0) begin
                source_done[sidx] <= 1'b1;
                head_id[sidx]     <= NO_CLAUSE_ID;
                head_len[sidx]    <= '0;
              end else begin
                head_id[sidx]  <= clause_id;
                head_len[sidx] <= (clause_id == NO_CLAUSE_ID) ? '0 : lit_sat;
              end
              head_fill[sidx] <= '0;
            end
          end
          OP_APPEND: begin
            if (app_ok) begin
              head_fill[sidx] <= head_fill[sidx] + LW'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_init) begin
        i       <= '0;
        cnt     <= eff_count;
        cur     <= NO_CLAUSE_ID;
        win     <= '0;
        win_len <= '0;
        have    <= 1'b0;
        mism    <= 1'b0;
        freed   <= '0;
      end
      if (cmd.next_i || cmd.drop) begin
        i <= i + CW'(1);
      end
      if (cmd.take_min) begin
        cur     <= head_id[ii];
        win     <= ii;
        win_len <= head_len[ii];
        have    <= 1'b1;
      end
      if (cmd.cmp_init || cmd.out_init) begin
        k <= '0;
      end
      if (cmd.k_inc) begin
        k <= k + LW'(1);
      end
      if (cmd.drop) begin
        mism          <= mism | cmd.flag_mism;
        head_id[ii]   <= NO_CLAUSE_ID;
        head_len[ii]  <= '0;
        head_fill[ii] <= '0;
        if (32'(ii) < 8) begin
          freed[3'(ii)] <= 1'b1;
        end
      end
      if (cmd.out_init && have && (32'(win) < 8)) begin
        freed[3'(win)] <= 1'b1;
      end
      if (cmd.finish && have) begin
        head_id[win]   <= NO_CLAUSE_ID;
        head_len[win]  <= '0;
        head_fill[win] <= '0;
      end
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      merged_id     <= cur;
      winner_source <= 3'(win);
      out_literal   <= sts.win_empty ? 32'sd0 : $signed(rd_a);
      literal_valid <= !sts.win_empty;
      last          <= sts.win_empty || sts.k_last;
      mismatch      <= mism;
      freed_sources <= freed;
    end
  end

endmodule

[design/kway_clause_merge_dedup_core.sv]
// ----------------------------------------------------------------------------
// kway_clause_merge_dedup_core
// K-way merge of sorted clause streams with duplicate removal.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// request   start / busy           op, source, clause_id, lit_count, literal
// result    result_valid strobe    merged_id, winner_source, out_literal,
//                                  literal_valid, last, mismatch, freed_sources
// config    cfg_we                 cfg_wdata (source_count)
//
// Begin, append and end requests are handled in the idle state. A next request
// scans the sources, compares the literals of each duplicate and streams the
// results, driven by the single sequencer and the literal RAM read ports.
// Reset is synchronous; the literal RAM is not cleared. Results are strobed
// for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module kway_clause_merge_dedup_core #(
  parameter int MAX_SOURCES = kcm_pkg::MAX_SOURCES_DEF,
  parameter int MAX_LITS    = kcm_pkg::MAX_LITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [2:0]         source,
  input  logic [63:0]        clause_id,
  input  logic [5:0]         lit_count,
  input  logic signed [31:0] literal,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output logic               result_valid,
  output logic [63:0]        merged_id,
  output logic [2:0]         winner_source,
  output logic signed [31:0] out_literal,
  output logic               literal_valid,
  output logic               last,
  output logic               mismatch,
  output logic [7:0]         freed_sources
);
  import kcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kcm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  kcm_dp #(.MAX_SOURCES(MAX_SOURCES), .MAX_LITS(MAX_LITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .source        (source),
    .clause_id     (clause_id),
    .lit_count     (lit_count),
    .literal       (literal),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .merged_id     (merged_id),
    .winner_source (winner_source),
    .out_literal   (out_literal),
    .literal_valid (literal_valid),
    .last          (last),
    .mismatch      (mismatch),
    .freed_sources (freed_sources),
    .result_valid  (result_valid)
  );

endmodule

[design/kcm_checker.sv]
// ----------------------------------------------------------------------------
// kcm_checker
// Port-level checks for the clause merge core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kcm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         op,
  input logic               result_valid,
  input logic [63:0]        merged_id,
  input logic               literal_valid,
  input logic               last,
  input logic               mismatch
);
  import kcm_pkg::*;

  `KCM_ASSERT_IMP(a_empty_last, clk, rst, result_valid && !literal_valid, last, "empty result without last")
  `KCM_ASSERT_IMP(a_last_idle, clk, rst, result_valid && last, !busy, "busy after last result")
  `KCM_ASSERT_NXT(a_next_busy, clk, rst, start && !busy && op == OP_NEXT, busy, "next request not taken")
  `KCM_ASSERT_IMP(a_stream_gap, clk, rst, result_valid && !last, ##2 result_valid, "result stream broken")
  `KCM_ASSERT_IMP(a_mism_win, clk, rst, result_valid && mismatch, merged_id != NO_CLAUSE_ID, "mismatch without winner")

endmodule

bind kway_clause_merge_dedup_core kcm_checker u_kcm_checker (.*);
